// ===== hw/rtl/itoa_pkg.sv =====
package itoa_pkg;

  typedef enum logic [1:0] {
    ACT_SDEC = 2'd0,
    ACT_UDEC = 2'd1,
    ACT_LHEX = 2'd2,
    ACT_UHEX = 2'd3
  } action_e;

  localparam int unsigned CountW    = 31;
  localparam int unsigned DecW      = 34;  // magnitude width for decimal digit extraction
  localparam int unsigned PosW      = 4;
  localparam logic [PosW-1:0] DecTopPos = 4'd9;
  localparam logic [PosW-1:0] HexTopPos = 4'd15;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharMinus = 8'h2d;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharUpA   = 8'h41;

  typedef struct packed {
    logic load;  // take a new word from the input port
    logic sign;  // emit the minus sign
    logic step;  // process one digit position
  } cmd_t;

  typedef struct packed {
    logic out_free;  // output register can take a character this cycle
    logic in_neg;    // word at the input is a negative signed decimal
    logic last_pos;  // current digit position is the least significant one
  } status_t;

  function automatic logic [DecW-1:0] pow10(input logic [PosW-1:0] pos);
    logic [DecW-1:0] p;
    unique case (pos)
      4'd0:    p = 34'd1;
      4'd1:    p = 34'd10;
      4'd2:    p = 34'd100;
      4'd3:    p = 34'd1000;
      4'd4:    p = 34'd10000;
      4'd5:    p = 34'd100000;
      4'd6:    p = 34'd1000000;
      4'd7:    p = 34'd10000000;
      4'd8:    p = 34'd100000000;
      4'd9:    p = 34'd1000000000;
      default: p = '0;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] digit, input logic upper);
    logic [7:0] c;
    if (digit < 4'd10) begin
      c = CharZero + {4'b0, digit};
    end else begin
      c = (upper ? CharUpA : CharLowA) + {4'b0, digit} - 8'd10;
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/integer_to_ascii_formatter_unit.sv =====
// Integer to ASCII formatter. Each input word carries a number and an action
// (signed 32-bit decimal, unsigned 32-bit decimal, lowercase or uppercase
// 64-bit hex); the block returns its characters most significant first, one
// output word per character, with leading zeros dropped, a single '0' for
// zero and a leading '-' for negative signed values (the most negative value
// prints in full). last_o marks the final character of a number and
// total_count_o carries the running character count since reset, saturating
// at 2^31-1. The word is taken in the idle state, then the digit positions
// are stepped from the top: 10 in decimal (plus a sign step for a negative
// value) and 16 in hex; no new word is taken until the last position is done.
// The digit sequencer handles one position per cycle while the output
// register is free: decimal digits come from a compare against the nine
// multiples of the current power of ten and a subtract, hex digits from a
// nibble shift. Suppressed leading zeros still take a step. The output register
// holds the last character of a number while the next is already being taken.
module integer_to_ascii_formatter_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  action_i,
  input  logic [63:0]                 number_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [7:0]                  character_o,
  output logic                        last_o,
  output logic [itoa_pkg::CountW-1:0] total_count_o
);
  import itoa_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Controller: idle / sign / digit sequencing, stalls on the output register.
  itoa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath: magnitude register, digit extraction, char count, output register.
  itoa_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .action_i      (action_i),
    .number_i      (number_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .character_o   (character_o),
    .last_o        (last_o),
    .total_count_o (total_count_o),
    .cmd_i         (cmd),
    .status_o      (status)
  );

endmodule

// ===== hw/rtl/itoa_ctrl.sv =====
module itoa_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  itoa_pkg::status_t status_i,
  output itoa_pkg::cmd_t    cmd_o
);
  import itoa_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SIGN  = 3'b010,
    ST_DIGIT = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.in_neg ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN: begin
        if (status_i.out_free) begin
          cmd_o.sign = 1'b1;
          state_d    = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (status_i.out_free) begin
          cmd_o.step = 1'b1;
          if (status_i.last_pos) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/itoa_dpath.sv =====
module itoa_dpath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [1:0]                action_i,
  input  logic [63:0]               number_i,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic [7:0]                character_o,
  output logic                      last_o,
  output logic [itoa_pkg::CountW-1:0] total_count_o,
  input  itoa_pkg::cmd_t             cmd_i,
  output itoa_pkg::status_t          status_o
);
  import itoa_pkg::*;

  logic [63:0]       mag_q, mag_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic              hex_q, hex_d;
  logic              upper_q, upper_d;
  logic              started_q, started_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        char_q, char_d;
  logic              last_q, last_d;
  logic [CountW-1:0] total_q, total_d;

  logic [31:0]       low;
  logic [32:0]       neg_mag;
  logic [DecW-1:0]   mag_dec, pw, sub;
  logic [DecW-1:0]   mult [10];
  logic [3:0]        dec_digit, digit;
  logic              emit, out_load;
  logic [CountW-1:0] cnt_inc;

  assign low     = number_i[31:0];
  assign neg_mag = 33'h1_0000_0000 - {1'b0, low};

  // Decimal digit: compare the magnitude against every multiple of the
  // current power of ten and keep the largest one that fits.
  assign mag_dec = mag_q[DecW-1:0];
  assign pw      = pow10(pos_q);

  always_comb begin
    mult[0]   = '0;
    dec_digit = '0;
    for (int k = 1; k < 10; k++) begin
      mult[k] = pw * DecW'(k);
    end
    for (int k = 1; k < 10; k++) begin
      if (mag_dec >= mult[k]) begin
        dec_digit = 4'(k);
      end
    end
  end

  assign sub   = mult[dec_digit];
  assign digit = hex_q ? mag_q[63:60] : dec_digit;
  // Leading zeros are dropped, but the units position always prints.
  assign emit  = started_q || (digit != 4'd0) || (pos_q == '0);

  assign out_load = cmd_i.sign || (cmd_i.step && emit);
  assign cnt_inc  = (cnt_q == CountMax) ? cnt_q : cnt_q + 1'b1;

  always_comb begin
    mag_d     = mag_q;
    pos_d     = pos_q;
    hex_d     = hex_q;
    upper_d   = upper_q;
    started_d = started_q;
    if (cmd_i.load) begin
      hex_d     = action_i[1];
      upper_d   = (action_i == ACT_UHEX);
      started_d = 1'b0;
      pos_d     = action_i[1] ? HexTopPos : DecTopPos;
      if (action_i[1]) begin
        mag_d = number_i;
      end else if ((action_i == ACT_SDEC) && low[31]) begin
        mag_d = {31'b0, neg_mag};
      end else begin
        mag_d = {32'b0, low};
      end
    end else if (cmd_i.step) begin
      started_d = emit;
      pos_d     = pos_q - 1'b1;
      if (hex_q) begin
        mag_d = {mag_q[59:0], 4'b0};
      end else begin
        mag_d = {{(64-DecW){1'b0}}, mag_dec - sub};
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    char_d      = char_q;
    last_d      = last_q;
    total_d     = total_q;
    cnt_d       = cnt_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      char_d      = cmd_i.sign ? CharMinus : digit_char(digit, upper_q);
      last_d      = cmd_i.step && (pos_q == '0);
      total_d     = cnt_inc;
      cnt_d       = cnt_inc;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      started_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      started_q   <= started_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    pos_q   <= pos_d;
    hex_q   <= hex_d;
    upper_q <= upper_d;
    char_q  <= char_d;
    last_q  <= last_d;
    total_q <= total_d;
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign status_o.in_neg   = (action_i == ACT_SDEC) && low[31];
  assign status_o.last_pos = (pos_q == '0);

  assign out_valid_o   = out_valid_q;
  assign character_o   = char_q;
  assign last_o        = last_q;
  assign total_count_o = total_q;

endmodule

// ===== hw/rtl/itoa_checker.sv =====
module itoa_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [7:0]                  character_o,
  input logic                        last_o,
  input logic [itoa_pkg::CountW-1:0] total_count_o
);
  import itoa_pkg::*;

  logic [CountW-1:0] prev_total_q;
  logic              out_acc;

  assign out_acc = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_total_q <= '0;
    end else if (out_acc) begin
      prev_total_q <= total_count_o;
    end
  end

  // A stalled output word holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(character_o) && $stable(last_o) && $stable(total_count_o))
    else $error("output word changed while stalled");

  // Count steps by one per delivered character until it saturates.
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> (total_count_o == prev_total_q + 1'b1) ||
                ((prev_total_q == CountMax) && (total_count_o == CountMax)))
    else $error("character count out of sequence");

  // The minus sign is never the final character.
  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (character_o == CharMinus) |-> !last_o)
    else $error("minus sign flagged as last");

  // A number is being formatted right after it is taken.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again without formatting");

  // Only digits, hex letters and the minus sign appear.
  a_charset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((character_o >= 8'h30) && (character_o <= 8'h39)) ||
                    ((character_o >= 8'h61) && (character_o <= 8'h66)) ||
                    ((character_o >= 8'h41) && (character_o <= 8'h46)) ||
                    (character_o == CharMinus))
    else $error("illegal character");

endmodule

bind integer_to_ascii_formatter_unit itoa_checker u_itoa_checker (.*);
